// ===== design/hex_directory_record_parser_defines.svh =====
// Assertion macros for the hex directory record parser.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef HEX_DIRECTORY_RECORD_PARSER_DEFINES_SVH
`define HEX_DIRECTORY_RECORD_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define HDRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HDRP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HDRP_ASSERT(lbl, prop, msg)
`define HDRP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/hdrp_pkg.sv =====
// Package for the hex directory record parser: item types, codes and the
// hex digit decode. No dependencies.
`timescale 1ns / 1ps

package hdrp_pkg;

  localparam int MaxHexChars = 8192;
  localparam int QueueDepth  = 4;
  localparam int ByteOffW    = 13;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam int         HexDigitTen = 10;
  localparam logic [13:0] MinChars  = 14'd4;

  localparam logic KindHeader = 1'b0;
  localparam logic KindName   = 1'b1;

  localparam logic [1:0] FtUnknown = 2'd0;
  localparam logic [1:0] FtDir     = 2'd1;
  localparam logic [1:0] FtReg     = 2'd2;

  typedef struct packed {
    logic [7:0]  hex_char;
    logic [13:0] total_chars;
    logic        first;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] inode_num;
    logic [11:0] name_length;
    logic [1:0]  file_type;
    logic [7:0]  name_byte;
    logic        last_in_entry;
  } out_item_t;

  // One decoded byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0]          data;
    logic [ByteOffW-1:0] pos;
    logic [ByteOffW-1:0] raw_len;
    logic                restart;
  } byte_ev_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = '0;
    if (c >= CharZero && c <= CharNine) begin
      v = c[3:0];
    end else if (c >= CharLowA && c <= CharLowF) begin
      v = 4'(c - CharLowA + 8'(HexDigitTen));
    end
    return v;
  endfunction

  function automatic logic [1:0] file_type_of(input logic [7:0] b);
    logic [1:0] ft;
    if (b == 8'd0) begin
      ft = FtUnknown;
    end else if (b == 8'd1) begin
      ft = FtDir;
    end else begin
      ft = FtReg;
    end
    return ft;
  endfunction

endpackage

// ===== design/hdrp_queue.sv =====
// Short register queue of decoded bytes between the front and the back.
// Depends on hdrp_pkg.
`timescale 1ns / 1ps

module hdrp_queue #(
  parameter int DEPTH = hdrp_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hdrp_pkg::byte_ev_t   push_data_i,
  input  logic                 pop_i,
  output hdrp_pkg::byte_ev_t   pop_data_o,
  output hdrp_pkg::q_status_t  status_o
);
  import hdrp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  byte_ev_t            mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

// ===== design/hdrp_front.sv =====
// Front of the parser: takes hex characters, pairs nibbles into bytes and
// drops what lies beyond the decoded length. Depends on hdrp_pkg.
`timescale 1ns / 1ps

module hdrp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hdrp_pkg::in_item_t   in_item_i,
  input  hdrp_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output hdrp_pkg::byte_ev_t   push_data_o
);
  import hdrp_pkg::*;

  localparam logic [16:0] MaxHex = 17'(MaxHexChars);

  logic                nib_phase_q, nib_phase_d, nib_phase_cur;
  logic [3:0]          high_nib_q, high_nib_d, high_nib_cur;
  logic [ByteOffW-1:0] offset_q, offset_d, offset_cur;
  logic                pend_q, pend_d, pend_cur;
  logic                accept;
  logic [13:0]         total_clamp;
  logic [ByteOffW-1:0] raw_len;
  logic [3:0]          low_nib;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  always_comb begin
    total_clamp = ({3'b000, in_item_i.total_chars} > MaxHex) ? MaxHex[13:0]
                                                             : in_item_i.total_chars;
    raw_len     = total_clamp[13:1];
    low_nib     = hex_value(in_item_i.hex_char);

    // A new stream clears the pairing state before this character counts.
    nib_phase_cur = in_item_i.first ? 1'b0 : nib_phase_q;
    high_nib_cur  = in_item_i.first ? 4'd0 : high_nib_q;
    offset_cur    = in_item_i.first ? '0 : offset_q;
    pend_cur      = in_item_i.first | pend_q;

    nib_phase_d = nib_phase_q;
    high_nib_d  = high_nib_q;
    offset_d    = offset_q;
    pend_d      = pend_q;
    push_o      = 1'b0;

    if (accept) begin
      nib_phase_d = nib_phase_cur;
      high_nib_d  = high_nib_cur;
      offset_d    = offset_cur;
      pend_d      = pend_cur;
      if (total_clamp >= MinChars && offset_cur < raw_len) begin
        if (!nib_phase_cur) begin
          high_nib_d  = low_nib;
          nib_phase_d = 1'b1;
        end else begin
          nib_phase_d = 1'b0;
          offset_d    = offset_cur + 1'b1;
          pend_d      = 1'b0;
          push_o      = 1'b1;
        end
      end
    end

    push_data_o.data    = {high_nib_cur, low_nib};
    push_data_o.pos     = offset_cur;
    push_data_o.raw_len = raw_len;
    push_data_o.restart = pend_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_phase_q <= 1'b0;
      high_nib_q  <= '0;
      offset_q    <= '0;
      pend_q      <= 1'b0;
    end else begin
      nib_phase_q <= nib_phase_d;
      high_nib_q  <= high_nib_d;
      offset_q    <= offset_d;
      pend_q      <= pend_d;
    end
  end

endmodule

// ===== design/hdrp_back.sv =====
// Back of the parser: walks the count, record headers and names byte by
// byte and drives the registered result port. Depends on hdrp_pkg.
`timescale 1ns / 1ps

module hdrp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hdrp_pkg::q_status_t  q_status_i,
  input  hdrp_pkg::byte_ev_t   ev_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hdrp_pkg::out_item_t  out_item_o
);
  import hdrp_pkg::*;

  typedef enum logic [2:0] {
    PhCntLo,
    PhCntHi,
    PhHeader,
    PhName,
    PhDone
  } phase_e;

  localparam logic [2:0] HdrLenLo = 3'd4;
  localparam logic [2:0] HdrLenHi = 3'd5;

  phase_e      phase_q, phase_d, phase_cur;
  logic [7:0]  cnt_lo_q, cnt_lo_d, cnt_lo_cur;
  logic [15:0] entries_q, entries_d, entries_cur;
  logic [2:0]  hidx_q, hidx_d, hidx_cur;
  logic [31:0] ino_q, ino_d, ino_cur;
  logic [15:0] nlen_q, nlen_d, nlen_cur;
  logic [1:0]  ft_q, ft_d, ft_cur;
  logic [15:0] nleft_q, nleft_d, nleft_cur;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q, out_item_d;
  logic        emit;
  out_item_t   emit_item;
  logic [7:0]  b;
  logic [15:0] entries_dec;
  logic [15:0] nleft_dec;
  logic [16:0] name_end;

  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign b     = ev_i.data;

  always_comb begin
    phase_cur   = ev_i.restart ? PhCntLo : phase_q;
    cnt_lo_cur  = ev_i.restart ? 8'd0 : cnt_lo_q;
    entries_cur = ev_i.restart ? 16'd0 : entries_q;
    hidx_cur    = ev_i.restart ? 3'd0 : hidx_q;
    ino_cur     = ev_i.restart ? 32'd0 : ino_q;
    nlen_cur    = ev_i.restart ? 16'd0 : nlen_q;
    ft_cur      = ev_i.restart ? FtUnknown : ft_q;
    nleft_cur   = ev_i.restart ? 16'd0 : nleft_q;

    entries_dec = entries_cur - 1'b1;
    nleft_dec   = nleft_cur - 1'b1;
    name_end    = {4'd0, ev_i.pos} + 17'd1 + {1'b0, nlen_cur};

    phase_d   = phase_q;
    cnt_lo_d  = cnt_lo_q;
    entries_d = entries_q;
    hidx_d    = hidx_q;
    ino_d     = ino_q;
    nlen_d    = nlen_q;
    ft_d      = ft_q;
    nleft_d   = nleft_q;

    emit                    = 1'b0;
    emit_item.kind          = KindHeader;
    emit_item.inode_num     = ino_cur;
    emit_item.name_length   = nlen_cur[11:0];
    emit_item.file_type     = ft_cur;
    emit_item.name_byte     = 8'd0;
    emit_item.last_in_entry = 1'b0;

    if (pop_o) begin
      phase_d   = phase_cur;
      cnt_lo_d  = cnt_lo_cur;
      entries_d = entries_cur;
      hidx_d    = hidx_cur;
      ino_d     = ino_cur;
      nlen_d    = nlen_cur;
      ft_d      = ft_cur;
      nleft_d   = nleft_cur;

      unique case (phase_cur)
        PhCntLo: begin
          cnt_lo_d = b;
          phase_d  = PhCntHi;
        end
        PhCntHi: begin
          entries_d = {b, cnt_lo_cur};
          hidx_d    = 3'd0;
          phase_d   = ({b, cnt_lo_cur} == 16'd0) ? PhDone : PhHeader;
        end
        PhHeader: begin
          case (hidx_cur) inside
            [3'd0:3'd3]: begin
              ino_d[{hidx_cur[1:0], 3'b000} +: 8] = b;
              hidx_d = hidx_cur + 1'b1;
            end
            HdrLenLo: begin
              nlen_d = {8'd0, b};
              hidx_d = HdrLenHi;
            end
            HdrLenHi: begin
              nlen_d = {b, nlen_cur[7:0]};
              hidx_d = hidx_cur + 1'b1;
            end
            default: begin
              // Type byte closes the header.
              ft_d   = file_type_of(b);
              hidx_d = 3'd0;
              if (name_end > {4'd0, ev_i.raw_len}) begin
                phase_d = PhDone;
              end else begin
                emit                = 1'b1;
                emit_item.file_type = file_type_of(b);
                if (nlen_cur == 16'd0) begin
                  emit_item.last_in_entry = 1'b1;
                  entries_d = entries_dec;
                  phase_d   = (entries_dec == 16'd0) ? PhDone : PhHeader;
                end else begin
                  nleft_d = nlen_cur;
                  phase_d = PhName;
                end
              end
            end
          endcase
        end
        PhName: begin
          emit                    = 1'b1;
          emit_item.kind          = KindName;
          emit_item.name_byte     = b;
          emit_item.last_in_entry = (nleft_dec == 16'd0);
          nleft_d                 = nleft_dec;
          if (nleft_dec == 16'd0) begin
            entries_d = entries_dec;
            hidx_d    = 3'd0;
            phase_d   = (entries_dec == 16'd0) ? PhDone : PhHeader;
          end
        end
        PhDone: begin
          phase_d = PhDone;
        end
        default: begin
          phase_d = PhDone;
        end
      endcase
    end

    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (pop_o) begin
      out_valid_d = emit;
      out_item_d  = emit_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhCntLo;
      cnt_lo_q    <= '0;
      entries_q   <= '0;
      hidx_q      <= '0;
      ino_q       <= '0;
      nlen_q      <= '0;
      ft_q        <= FtUnknown;
      nleft_q     <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      cnt_lo_q    <= cnt_lo_d;
      entries_q   <= entries_d;
      hidx_q      <= hidx_d;
      ino_q       <= ino_d;
      nlen_q      <= nlen_d;
      ft_q        <= ft_d;
      nleft_q     <= nleft_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== design/hex_directory_record_parser.sv =====
// Hex directory record parser: one hex character in per item, directory
// entry headers and name bytes out, at most one result per character.
// The input channel carries hex_char, total_chars and first; first marks the
// opening character of a new directory and clears all parsing state.
// Two characters make one byte; the front part pairs them, drops anything
// past the decoded length and pushes each byte into a four-entry queue.
// The back part takes one byte per cycle from the queue while its result
// register is free or being taken, walks the entry count, the record
// headers and the names, and loads the result register. Throughput is one
// character per cycle unless the queue is full: the front takes a character
// every cycle and the back steps one byte per cycle, twice the byte arrival
// rate. With the queue empty, the byte that an accepted character completes
// goes into the queue, then into the result register behind out_valid_o.
// When the receiver stalls, the result register holds its item and the
// queue fills; in_stall_o rises only once the queue is full.
// After reset both parts are idle, the queue is empty, and the parser
// waits for the low byte of the entry count, as if a stream had started.
// Depends on hdrp_pkg, hdrp_front, hdrp_queue, hdrp_back and the
// assertion macro header.
`timescale 1ns / 1ps
`include "hex_directory_record_parser_defines.svh"

module hex_directory_record_parser #(
  parameter int QUEUE_DEPTH = hdrp_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hdrp_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hdrp_pkg::out_item_t  out_item_o
);
  import hdrp_pkg::*;

  logic      q_push;
  logic      q_pop;
  byte_ev_t  q_push_data;
  byte_ev_t  q_pop_data;
  q_status_t q_status;

  // Front: character pairing and length checks.
  hdrp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_status_i  (q_status),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  // Queue that lets the front keep taking characters while a result waits.
  hdrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .status_o    (q_status)
  );

  // Back: record parsing and the result register.
  hdrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .ev_i        (q_pop_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // The front must never push into a full queue, nor the back pop an empty one.
  `HDRP_ASSERT_NEVER(a_push_full, q_push && q_status.full, "push into full queue")
  `HDRP_ASSERT_NEVER(a_pop_empty, q_pop && q_status.empty, "pop from empty queue")
  // A new result can only come from a byte taken out of the queue.
  `HDRP_ASSERT(a_result_src, $rose(out_valid_o) |-> $past(q_pop), "result without a byte")

endmodule

// ===== bench/tb_hex_directory_record_parser.sv =====
// Self-checking bench for hex_directory_record_parser: drives hex characters of
// directory data with random idle and stall gaps and predicts every result.
// Depends on hdrp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_hex_directory_record_parser;
  import hdrp_pkg::*;

  localparam int ClampChars  = 8192;
  localparam int FewestChars = 4;
  localparam int RandomChars = 750;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 600000;

  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowF = 8'h66;

  typedef enum logic [2:0] {
    WalkCountLo,
    WalkCountHi,
    WalkHeader,
    WalkName,
    WalkDone
  } walk_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      chr_valid = 1'b0;
  logic      chr_stall;
  in_item_t  chr_item  = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;

  hex_directory_record_parser uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (chr_valid),
    .in_stall_o (chr_stall),
    .in_item_i  (chr_item),
    .out_valid_o(res_valid),
    .out_stall_i(res_stall),
    .out_item_o (res_item)
  );

  always #6 clk = ~clk;

  // Walk state of the directory being predicted.
  logic        w_half;
  logic [3:0]  w_hi;
  logic [12:0] w_off;
  walk_e       w_step;
  logic [7:0]  w_cnt_lo;
  logic [15:0] w_left;
  int unsigned w_hdr;
  logic [31:0] w_ino;
  logic [15:0] w_nlen;
  logic [7:0]  w_type;
  logic [15:0] w_name_left;

  out_item_t   dir_results_due[$];
  logic [7:0]  blob[$];
  bit          idle_on = 1'b1;
  int          faults = 0;
  int          chars_sent = 0;
  int          cycles = 0;
  int          hold_left = 0;
  int          run_left = 0;
  out_item_t   want;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return 4'(c - ChZero);
    if (c >= ChLowA && c <= ChLowF) return 4'(c - ChLowA + 8'd10);
    return 4'd0;
  endfunction

  function automatic void clear_walk();
    w_half      = 1'b0;
    w_hi        = '0;
    w_off       = '0;
    w_step      = WalkCountLo;
    w_cnt_lo    = '0;
    w_left      = '0;
    w_hdr       = 0;
    w_ino       = '0;
    w_nlen      = '0;
    w_type      = '0;
    w_name_left = '0;
  endfunction

  function automatic void push_result(input logic kind, input logic [7:0] b, input logic last);
    out_item_t r;
    r.kind          = kind;
    r.inode_num     = w_ino;
    r.name_length   = w_nlen[11:0];
    r.file_type     = (w_type == 8'd0) ? FtUnknown : (w_type == 8'd1) ? FtDir : FtReg;
    r.name_byte     = b;
    r.last_in_entry = last;
    dir_results_due.push_back(r);
  endfunction

  function automatic void close_entry();
    w_left = w_left - 16'd1;
    w_step = (w_left == 16'd0) ? WalkDone : WalkHeader;
    w_hdr  = 0;
  endfunction

  // Takes one accepted character and queues whatever result it completes.
  function automatic void walk_dir_char(input in_item_t it);
    int unsigned total;
    int unsigned raw_len;
    int unsigned pos;
    logic [7:0]  b;
    if (it.first) clear_walk();
    total   = (it.total_chars > ClampChars) ? ClampChars : it.total_chars;
    raw_len = total / 2;
    if (total >= FewestChars && w_off < raw_len) begin
      if (!w_half) begin
        w_hi   = digit_of(it.hex_char);
        w_half = 1'b1;
      end else begin
        w_half = 1'b0;
        b      = {w_hi, digit_of(it.hex_char)};
        pos    = w_off;
        w_off  = w_off + 13'd1;
        case (w_step)
          WalkCountLo: begin
            w_cnt_lo = b;
            w_step   = WalkCountHi;
          end
          WalkCountHi: begin
            w_left = {b, w_cnt_lo};
            w_hdr  = 0;
            w_step = (w_left == 16'd0) ? WalkDone : WalkHeader;
          end
          WalkHeader: begin
            if (w_hdr < 4) begin
              w_ino[8*w_hdr +: 8] = b;
              w_hdr++;
            end else if (w_hdr == 4) begin
              w_nlen = {8'd0, b};
              w_hdr  = 5;
            end else if (w_hdr == 5) begin
              w_nlen[15:8] = b;
              w_hdr        = 6;
            end else begin
              w_type = b;
              w_hdr  = 0;
              // A name running past the decoded length ends the whole stream.
              if (pos + 1 + w_nlen > raw_len) begin
                w_step = WalkDone;
              end else if (w_nlen == 16'd0) begin
                push_result(KindHeader, 8'd0, 1'b1);
                close_entry();
              end else begin
                push_result(KindHeader, 8'd0, 1'b0);
                w_name_left = w_nlen;
                w_step      = WalkName;
              end
            end
          end
          WalkName: begin
            w_name_left = w_name_left - 16'd1;
            push_result(KindName, b, w_name_left == 16'd0);
            if (w_name_left == 16'd0) close_entry();
          end
          default: begin
          end
        endcase
      end
    end
  endfunction

  // Mostly no gap, some short ones and now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] char_for(input logic [3:0] v, input bit noisy);
    logic [7:0] c;
    c = (v < 4'd10) ? 8'(ChZero + v) : 8'(ChLowA + v - 4'd10);
    // Any character other than a lowercase hex digit stands for zero.
    if (noisy && v == 4'd0 && $urandom_range(0, 1) == 1) begin
      c = 8'($urandom_range(0, 255));
      while (digit_of(c) != 4'd0) c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic note_fault(input string what, input out_item_t exp_r, input out_item_t got);
    faults++;
    if (faults <= 10) begin
      $display("%s: expected kind %0d ino %h len %0d type %0d byte %h last %0d",
               what, exp_r.kind, exp_r.inode_num, exp_r.name_length, exp_r.file_type,
               exp_r.name_byte, exp_r.last_in_entry);
      $display("  got kind %0d ino %h len %0d type %0d byte %h last %0d",
               got.kind, got.inode_num, got.name_length, got.file_type,
               got.name_byte, got.last_in_entry);
    end
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && res_valid && !res_stall) begin
      if (dir_results_due.size() == 0) begin
        note_fault("unexpected result", '0, res_item);
      end else begin
        want = dir_results_due.pop_front();
        if (want.kind !== res_item.kind || want.inode_num !== res_item.inode_num ||
            want.name_length !== res_item.name_length ||
            want.file_type !== res_item.file_type ||
            want.name_byte !== res_item.name_byte ||
            want.last_in_entry !== res_item.last_in_entry)
          note_fault("result mismatch", want, res_item);
      end
    end
  end

  // Receiver: runs of acceptance broken by stalls of random length.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left  = $urandom_range(0, 6);
        hold_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_char(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      chr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chr_valid <= 1'b1;
    chr_item  <= it;
    @(posedge clk);
    while (chr_stall) @(posedge clk);
    walk_dir_char(it);
    chars_sent++;
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) blob.push_back(v[8*k +: 8]);
  endtask

  task automatic put_header(input logic [31:0] ino, input int nlen, input logic [7:0] ftype);
    put_le(ino, 4);
    put_le(nlen, 2);
    blob.push_back(ftype);
  endtask

  task automatic put_name(input int n);
    for (int k = 0; k < n; k++) blob.push_back(8'($urandom_range(0, 255)));
  endtask

  // Sends the collected bytes as hex characters, then extra random characters.
  task automatic send_blob(input int total, input bit with_first, input bit noisy,
                           input int extra);
    in_item_t   it;
    logic [7:0] cur;
    int         n;
    n = 2 * blob.size();
    for (int k = 0; k < n + extra; k++) begin
      it.total_chars = 14'(total);
      it.first       = with_first && (k == 0);
      if (k < n) begin
        cur         = blob[k / 2];
        it.hex_char = char_for((k % 2 == 1) ? cur[3:0] : cur[7:4], noisy);
      end else begin
        it.hex_char = 8'($urandom_range(0, 255));
      end
      send_char(it);
    end
    blob.delete();
  endtask

  task automatic await_results();
    chr_valid <= 1'b0;
    while (dir_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // The block starts a stream after reset without any first flag.
  task automatic test_after_reset();
    put_le(1, 2);
    put_header(32'hffff_ffff, 2, 8'd1);
    blob.push_back(8'h00);
    blob.push_back(8'hff);
    send_blob(2 * blob.size(), 1'b0, 1'b0, 0);
  endtask

  task automatic test_hex_digits();
    put_le(1, 2);
    put_header(32'h0, 8, 8'd7);
    put_le(32'h6745_2301, 4);
    put_le(32'hefcd_ab89, 4);
    send_blob(2 * blob.size(), 1'b1, 1'b1, 0);
  endtask

  // Empty names end an entry on its header; an odd trailing character is dropped.
  task automatic test_empty_names();
    put_le(3, 2);
    put_header(32'h1234_5678, 0, 8'd0);
    put_header(32'h9abc_def0, 0, 8'd1);
    put_header(32'h0000_0001, 1, 8'd200);
    blob.push_back(8'h41);
    send_blob(2 * blob.size() + 1, 1'b1, 1'b0, 1);
  endtask

  task automatic test_short_input();
    for (int t = 0; t <= FewestChars; t++) begin
      put_le(1, 2);
      put_header(32'd5, 0, 8'd1);
      send_blob(t, 1'b1, 1'b0, 0);
    end
  endtask

  task automatic test_zero_count();
    put_le(0, 2);
    put_header(32'd7, 0, 8'd2);
    send_blob(2 * blob.size(), 1'b1, 1'b0, 0);
  endtask

  task automatic test_count_exhausted();
    put_le(1, 2);
    put_header(32'd11, 1, 8'd1);
    put_name(1);
    put_header(32'd12, 0, 8'd0);
    send_blob(2 * blob.size(), 1'b1, 1'b0, 0);
  endtask

  // Names that overrun the decoded length stop the stream; a long one that fits
  // carries a nonzero upper length byte.
  task automatic test_name_overrun();
    put_le(2, 2);
    put_header(32'd21, 5, 8'd2);
    put_name(3);
    send_blob(2 * blob.size(), 1'b1, 1'b0, 0);
    put_le(1, 2);
    put_header(32'd22, 16'h1234, 8'd1);
    send_blob(ClampChars, 1'b1, 1'b0, 0);
    put_le(1, 2);
    put_header(32'd23, 256, 8'd2);
    put_name(256);
    send_blob(2 * blob.size(), 1'b1, 1'b0, 0);
  endtask

  task automatic test_length_clamp();
    put_le(1, 2);
    put_header(32'd31, 2, 8'd1);
    put_name(2);
    send_blob(16383, 1'b1, 1'b1, 0);
    put_le(1, 2);
    put_header(32'd32, 1, 8'd0);
    put_name(1);
    send_blob(ClampChars, 1'b1, 1'b0, 0);
  endtask

  // A first flag halfway through a header, and on the second character of a
  // byte, throws away everything gathered so far.
  task automatic test_restart();
    put_le(1, 2);
    put_le(32'hdead_beef, 3);
    send_blob(100, 1'b1, 1'b0, 1);
    put_le(2, 2);
    put_header(32'd41, 1, 8'd0);
    put_name(1);
    put_header(32'd42, 0, 8'd1);
    send_blob(2 * blob.size(), 1'b1, 1'b0, 0);
  endtask

  task automatic random_stream();
    int          r;
    int          n_rec;
    int          exact;
    int          total;
    int          extra;
    int          nlen;
    logic [15:0] cnt;
    logic [7:0]  ftype;
    r = $urandom_range(0, 99);
    if (r < 5) cnt = 16'd0;
    else if (r < 10) cnt = 16'($urandom_range(0, 65535));
    else cnt = 16'($urandom_range(1, 4));
    // Sometimes one record too many, so the count runs out first.
    n_rec = (cnt <= 16'd4) ? int'(cnt) + $urandom_range(0, 1) : $urandom_range(1, 4);
    put_le(cnt, 2);
    for (int k = 0; k < n_rec; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) nlen = $urandom_range(0, 6);
      else if (r < 95) nlen = $urandom_range(7, 20);
      else nlen = $urandom_range(21, 40);
      r = $urandom_range(0, 3);
      ftype = (r == 3) ? 8'($urandom_range(0, 255)) : 8'(r);
      put_header($urandom, nlen, ftype);
      put_name(nlen);
    end
    exact = 2 * blob.size();
    extra = 0;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      total = exact;
    end else if (r < 85) begin
      total = $urandom_range(FewestChars, exact);
    end else if (r < 92) begin
      total = exact + 1;
      extra = 1;
    end else begin
      total = $urandom_range(exact, 16383);
      extra = $urandom_range(0, 6);
    end
    send_blob(total, $urandom_range(0, 19) != 0, $urandom_range(0, 2) == 0, extra);
  endtask

  // Raw characters with a fresh length on every item.
  task automatic noise_stream();
    in_item_t it;
    int       len;
    len = $urandom_range(4, 24);
    for (int k = 0; k < len; k++) begin
      it.hex_char    = 8'($urandom_range(0, 255));
      it.total_chars = 14'($urandom_range(0, 16383));
      it.first       = ($urandom_range(0, 7) == 0);
      send_char(it);
    end
  endtask

  task automatic test_random_streams();
    int start;
    bit paused;
    start  = chars_sent;
    paused = 1'b0;
    while (chars_sent - start < RandomChars) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) noise_stream();
      else random_stream();
      // Once, the sender holds off until the parser has delivered everything.
      if (!paused && chars_sent - start > RandomChars / 2) begin
        await_results();
        paused = 1'b1;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    clear_walk();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_hex_digits();
    test_empty_names();
    test_short_input();
    test_zero_count();
    test_count_exhausted();
    test_name_overrun();
    test_length_clamp();
    test_restart();
    test_random_streams();
    await_results();
    if (dir_results_due.size() != 0)
      $display("%0d expected results never arrived", dir_results_due.size());
    if (faults == 0 && dir_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/hdrp_pkg.sv
design/hdrp_queue.sv
design/hdrp_front.sv
design/hdrp_back.sv
design/hex_directory_record_parser.sv
bench/tb_hex_directory_record_parser.sv
